// ----- rtl/core/crs_pkg.sv -----
// Package for the clip rectangle stack: rectangle types, request codes and
// the span intersection function. No dependencies.
package crs_pkg;

  localparam int CoordW = 16;
  localparam int ExtW   = 15;

  typedef logic [1:0] req_t;

  localparam req_t ReqReset = 2'd0;
  localparam req_t ReqPush  = 2'd1;
  localparam req_t ReqPop   = 2'd2;
  localparam req_t ReqNop   = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] org;
    logic        [ExtW-1:0]   ext;
  } span_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [ExtW-1:0]   w;
    logic        [ExtW-1:0]   h;
  } rect_t;

  localparam int RectW = $bits(rect_t);

  // Overlap of two spans: larger origin, smaller far edge, empty clamps to zero.
  function automatic span_t span_meet(input logic signed [CoordW-1:0] a0,
                                      input logic        [ExtW-1:0]   ae,
                                      input logic signed [CoordW-1:0] b0,
                                      input logic        [ExtW-1:0]   be);
    logic signed [CoordW:0] lo;
    logic signed [CoordW:0] af;
    logic signed [CoordW:0] bf;
    logic signed [CoordW:0] hi;
    logic signed [CoordW:0] diff;
    span_t                  res;
    lo   = (a0 > b0) ? {a0[CoordW-1], a0} : {b0[CoordW-1], b0};
    af   = {a0[CoordW-1], a0} + $signed({2'b00, ae});
    bf   = {b0[CoordW-1], b0} + $signed({2'b00, be});
    hi   = (af < bf) ? af : bf;
    diff = hi - lo;
    res.org = lo[CoordW-1:0];
    res.ext = (hi > lo) ? diff[ExtW-1:0] : '0;
    return res;
  endfunction

endpackage

// ----- rtl/core/crs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module crs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/clip_rect_stack_top.sv -----
// Clip rectangle stack: top entry in registers, lower entries in crs_ram.
// Depends on crs_pkg and crs_ram.
// The done strobe follows start in the next cycle; one request per cycle, busy stays low.
// The top entry and the entry below it sit in registers, so each request
// needs only one short min/max intersect; the RAM read is addressed from the next level.
// Reset clears the level, the top entry and the area registers to zero.
module clip_rect_stack_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] rect_x_i,
  input  logic [15:0] rect_y_i,
  input  logic [14:0] rect_w_i,
  input  logic [14:0] rect_h_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        done_o,
  output logic [15:0] clip_x_o,
  output logic [15:0] clip_y_o,
  output logic [14:0] clip_w_o,
  output logic [14:0] clip_h_o,
  output logic        dropped_o
);

  localparam int LvlW = $clog2(STACK_DEPTH);
  localparam logic [LvlW-1:0] LvlMax = LvlW'(STACK_DEPTH - 1);

  localparam logic [1:0] CfgAreaX = 2'd0;
  localparam logic [1:0] CfgAreaY = 2'd1;
  localparam logic [1:0] CfgAreaW = 2'd2;
  localparam logic [1:0] CfgAreaH = 2'd3;

  crs_pkg::rect_t  area_q;
  crs_pkg::rect_t  top_q, top_d;
  crs_pkg::rect_t  below_q, below_d, below;
  crs_pkg::rect_t  push_rect;
  crs_pkg::rect_t  ram_rdata;
  crs_pkg::span_t  span_x, span_y;
  logic [LvlW-1:0] level_q, level_d;
  logic [LvlW-1:0] raddr;
  logic            from_mem_q, from_mem_d;
  logic            done_q, dropped_q, dropped_d;
  logic            push_ok;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAreaX: area_q.x <= cfg_wdata_i;
        CfgAreaY: area_q.y <= cfg_wdata_i;
        CfgAreaW: area_q.w <= cfg_wdata_i[14:0];
        CfgAreaH: area_q.h <= cfg_wdata_i[14:0];
        default:  area_q   <= area_q;
      endcase
    end
  end

  assign below = from_mem_q ? ram_rdata : below_q;

  assign span_x = crs_pkg::span_meet(rect_x_i, rect_w_i, top_q.x, top_q.w);
  assign span_y = crs_pkg::span_meet(rect_y_i, rect_h_i, top_q.y, top_q.h);

  always_comb begin
    push_rect   = top_q;
    push_rect.x = span_x.org;
    push_rect.w = span_x.ext;
    push_rect.y = span_y.org;
    push_rect.h = span_y.ext;
  end

  always_comb begin
    top_d      = top_q;
    level_d    = level_q;
    below_d    = below;
    from_mem_d = 1'b0;
    dropped_d  = 1'b0;
    push_ok    = 1'b0;
    if (start_i) begin
      unique case (req_type_i)
        crs_pkg::ReqReset: begin
          top_d   = area_q;
          level_d = '0;
        end
        crs_pkg::ReqPush: begin
          if (level_q < LvlMax) begin
            push_ok = 1'b1;
            top_d   = push_rect;
            below_d = top_q;
            level_d = level_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
        end
        crs_pkg::ReqPop: begin
          if (level_q != '0) begin
            top_d      = below;
            level_d    = level_q - 1'b1;
            from_mem_d = 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
        end
        crs_pkg::ReqNop: begin
          top_d = top_q;
        end
        default: begin
          top_d = top_q;
        end
      endcase
    end
  end

  // The RAM always reads the entry below the next top level.
  assign raddr = level_d - 1'b1;

  crs_ram #(
    .Width (crs_pkg::RectW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (level_q),
    .wdata_i (top_q),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= '0;
      level_q    <= '0;
      from_mem_q <= 1'b0;
      done_q     <= 1'b0;
      dropped_q  <= 1'b0;
    end else begin
      top_q      <= top_d;
      level_q    <= level_d;
      from_mem_q <= from_mem_d;
      done_q     <= start_i;
      dropped_q  <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    below_q <= below_d;
  end

  assign done_o    = done_q;
  assign clip_x_o  = top_q.x;
  assign clip_y_o  = top_q.y;
  assign clip_w_o  = top_q.w;
  assign clip_h_o  = top_q.h;
  assign dropped_o = dropped_q;

endmodule
